// File: rtl/spq_pkg.sv
// Shared types, constants and codes of the stable priority task queue.
package spq_pkg;

   localparam int DEPTH_DEFAULT         = 16;
   localparam int PRIORITY_BITS_DEFAULT = 8;
   localparam int HANDLE_BITS_DEFAULT   = 16;

   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 2;

   // command codes carried in req_tuser
   localparam logic [CMD_BITS-1:0] CMD_INSERT   = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_DISPATCH = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_FINISH   = 2'd2;

   // status codes carried in rsp_tuser
   localparam logic [STATUS_BITS-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL    = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NO_HEAD = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_TAG = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } ctrl_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // latch the accepted item
      logic execute;   // apply the latched item and load the result register
   } spq_ctl_type;

endpackage

// File: rtl/spq_ctrl.sv
// Controller of the stable priority task queue: item handshake and result valid.
module spq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output spq_pkg::spq_ctl_type ctl
);

   spq_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    can_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign can_load = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      req_tready   = 1'b0;
      ctl.capture  = 1'b0;
      ctl.execute  = 1'b0;
      case (state_ff)
         spq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.capture = 1'b1;
               state_in    = spq_pkg::ST_EXEC;
            end
         end
         spq_pkg::ST_EXEC: begin
            if (can_load) begin
               ctl.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = spq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// File: rtl/spq_datapath.sv
// Datapath of the stable priority task queue: sorted cell row, tag map, result register.
module spq_datapath #(
   parameter int DEPTH         = spq_pkg::DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEFAULT,
   parameter int HANDLE_BITS   = spq_pkg::HANDLE_BITS_DEFAULT,
   localparam int TAG_BITS     = $clog2(DEPTH),
   localparam int OCC_BITS     = $clog2(DEPTH + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  spq_pkg::spq_ctl_type            ctl,
   input  logic [spq_pkg::CMD_BITS-1:0]    req_cmd,
   input  logic [HANDLE_BITS-1:0]          req_handle,
   input  logic signed [PRIORITY_BITS-1:0] req_priority,
   input  logic [TAG_BITS-1:0]             req_finish_tag,
   output logic [spq_pkg::STATUS_BITS-1:0] rsp_status,
   output logic [HANDLE_BITS-1:0]          rsp_handle,
   output logic [TAG_BITS-1:0]             rsp_tag,
   output logic [OCC_BITS-1:0]             rsp_occupancy
);

   // latched item
   logic [spq_pkg::CMD_BITS-1:0]    cmd_ff;
   logic [HANDLE_BITS-1:0]          handle_ff;
   logic signed [PRIORITY_BITS-1:0] prio_ff;
   logic [TAG_BITS-1:0]             ftag_ff;

   // cell row, slot 0 is the head
   logic                            valid_ff  [DEPTH];
   logic                            busy_ff   [DEPTH];
   logic signed [PRIORITY_BITS-1:0] prio_c_ff [DEPTH];
   logic [HANDLE_BITS-1:0]          hndl_c_ff [DEPTH];
   logic [TAG_BITS-1:0]             tag_c_ff  [DEPTH];
   logic                            valid_in  [DEPTH];
   logic                            busy_in   [DEPTH];
   logic signed [PRIORITY_BITS-1:0] prio_c_in [DEPTH];
   logic [HANDLE_BITS-1:0]          hndl_c_in [DEPTH];
   logic [TAG_BITS-1:0]             tag_c_in  [DEPTH];

   logic [OCC_BITS-1:0]             count_ff, count_in;
   logic [DEPTH-1:0]                free_ff, free_in;

   logic [spq_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [HANDLE_BITS-1:0]          out_handle_ff, out_handle_in;
   logic [TAG_BITS-1:0]             out_tag_ff, out_tag_in;

   logic [DEPTH-1:0]                le;        // entry sorts at or before new item
   logic [DEPTH-1:0]                match;     // busy entry holding the finish tag
   logic [DEPTH-1:0]                low_free;  // lowest free tag, one-hot
   logic [TAG_BITS-1:0]             new_tag;
   logic [TAG_BITS-1:0]             match_pos;
   logic                            hit, full, head_ok;
   logic                            do_insert, do_dispatch, do_finish;

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff    <= req_cmd;
         handle_ff <= req_handle;
         prio_ff   <= req_priority;
         ftag_ff   <= req_finish_tag;
      end
   end

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         le[i]    = valid_ff[i] && (prio_c_ff[i] <= prio_ff);
         match[i] = valid_ff[i] && busy_ff[i] && (tag_c_ff[i] == ftag_ff);
      end
   end

   assign low_free = free_ff & (~free_ff + DEPTH'(1));

   // one-hot to index: at most one bit set in each vector
   always_comb begin
      new_tag   = '0;
      match_pos = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (low_free[i]) begin
            new_tag = new_tag | TAG_BITS'(i);
         end
         if (match[i]) begin
            match_pos = match_pos | TAG_BITS'(i);
         end
      end
   end

   assign hit         = |match;
   assign full        = (count_ff == OCC_BITS'(DEPTH));
   assign head_ok     = valid_ff[0] && !busy_ff[0];
   assign do_insert   = ctl.execute && (cmd_ff == spq_pkg::CMD_INSERT) && !full;
   assign do_dispatch = ctl.execute && (cmd_ff == spq_pkg::CMD_DISPATCH) && head_ok;
   assign do_finish   = ctl.execute && (cmd_ff == spq_pkg::CMD_FINISH) && hit;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic at_slot, from_prev, from_next;

      if (i == 0) begin : g_first
         assign at_slot   = !le[0];
         assign from_prev = 1'b0;
      end else begin : g_rest
         assign at_slot   = !le[i] && le[i-1];
         assign from_prev = !le[i] && !le[i-1];
      end
      assign from_next = do_finish && (TAG_BITS'(i) >= match_pos);

      always_comb begin
         valid_in[i]  = valid_ff[i];
         busy_in[i]   = busy_ff[i];
         prio_c_in[i] = prio_c_ff[i];
         hndl_c_in[i] = hndl_c_ff[i];
         tag_c_in[i]  = tag_c_ff[i];
         if (do_insert && at_slot) begin
            valid_in[i]  = 1'b1;
            busy_in[i]   = 1'b0;
            prio_c_in[i] = prio_ff;
            hndl_c_in[i] = handle_ff;
            tag_c_in[i]  = new_tag;
         end else if (do_insert && from_prev) begin
            if (i > 0) begin
               valid_in[i]  = valid_ff[(i > 0) ? i-1 : 0];
               busy_in[i]   = busy_ff[(i > 0) ? i-1 : 0];
               prio_c_in[i] = prio_c_ff[(i > 0) ? i-1 : 0];
               hndl_c_in[i] = hndl_c_ff[(i > 0) ? i-1 : 0];
               tag_c_in[i]  = tag_c_ff[(i > 0) ? i-1 : 0];
            end
         end else if (from_next) begin
            if (i == DEPTH-1) begin
               valid_in[i] = 1'b0;
               busy_in[i]  = 1'b0;
            end else begin
               valid_in[i]  = valid_ff[(i < DEPTH-1) ? i+1 : i];
               busy_in[i]   = busy_ff[(i < DEPTH-1) ? i+1 : i];
               prio_c_in[i] = prio_c_ff[(i < DEPTH-1) ? i+1 : i];
               hndl_c_in[i] = hndl_c_ff[(i < DEPTH-1) ? i+1 : i];
               tag_c_in[i]  = tag_c_ff[(i < DEPTH-1) ? i+1 : i];
            end
         end else if (do_dispatch && (i == 0)) begin
            busy_in[i] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
            busy_ff[i]  <= 1'b0;
         end else begin
            valid_ff[i] <= valid_in[i];
            busy_ff[i]  <= busy_in[i];
         end
         prio_c_ff[i] <= prio_c_in[i];
         hndl_c_ff[i] <= hndl_c_in[i];
         tag_c_ff[i]  <= tag_c_in[i];
      end
   end

   always_comb begin
      count_in      = count_ff;
      free_in       = free_ff;
      status_in     = status_ff;
      out_handle_in = out_handle_ff;
      out_tag_in    = out_tag_ff;
      if (ctl.execute) begin
         status_in     = spq_pkg::STATUS_OK;
         out_handle_in = '0;
         out_tag_in    = '0;
         case (cmd_ff)
            spq_pkg::CMD_INSERT: begin
               if (full) begin
                  status_in = spq_pkg::STATUS_FULL;
               end else begin
                  count_in   = count_ff + OCC_BITS'(1);
                  free_in    = free_ff & ~low_free;
                  out_tag_in = new_tag;
               end
            end
            spq_pkg::CMD_DISPATCH: begin
               if (head_ok) begin
                  out_handle_in = hndl_c_ff[0];
                  out_tag_in    = tag_c_ff[0];
               end else begin
                  status_in = spq_pkg::STATUS_NO_HEAD;
               end
            end
            spq_pkg::CMD_FINISH: begin
               if (hit) begin
                  count_in         = count_ff - OCC_BITS'(1);
                  free_in[ftag_ff] = 1'b1;
                  out_tag_in       = ftag_ff;
               end else begin
                  status_in = spq_pkg::STATUS_BAD_TAG;
               end
            end
            default: begin
               status_in = spq_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         free_ff  <= '1;
      end else begin
         count_ff <= count_in;
         free_ff  <= free_in;
      end
      status_ff     <= status_in;
      out_handle_ff <= out_handle_in;
      out_tag_ff    <= out_tag_in;
   end

   assign rsp_status    = status_ff;
   assign rsp_handle    = out_handle_ff;
   assign rsp_tag       = out_tag_ff;
   assign rsp_occupancy = count_ff;

endmodule

// File: rtl/stable_priority_task_queue.sv
// Top level of the stable priority task queue.
// An accepted item is latched in idle and applied in execute, where the cell row compares
// and shifts; its result is then registered and can be taken from the result register.
// No new item is taken while one is latched or in execute.
// A waiting result holds the item taken after it in execute; the input then stalls until
// the result is taken. Reset (synchronous, active high) empties the queue and frees all tags.
module stable_priority_task_queue #(
   parameter int DEPTH         = spq_pkg::DEPTH_DEFAULT,
   parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEFAULT,
   parameter int HANDLE_BITS   = spq_pkg::HANDLE_BITS_DEFAULT,
   localparam int TAG_BITS     = $clog2(DEPTH),
   localparam int OCC_BITS     = $clog2(DEPTH + 1),
   localparam int REQ_BITS     = HANDLE_BITS + PRIORITY_BITS + TAG_BITS,
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS     = HANDLE_BITS + TAG_BITS + OCC_BITS,
   localparam int RSP_DATA_W   = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // task_handle, task_priority, finish_tag (lowest bit up), zero pad
   input  logic [REQ_DATA_W-1:0]           req_tdata,
   // cmd
   input  logic [spq_pkg::CMD_BITS-1:0]    req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // out_handle, out_tag, occupancy (lowest bit up), zero pad
   output logic [RSP_DATA_W-1:0]           rsp_tdata,
   // status
   output logic [spq_pkg::STATUS_BITS-1:0] rsp_tuser
);

   spq_pkg::spq_ctl_type            ctl;
   logic [HANDLE_BITS-1:0]          in_handle;
   logic signed [PRIORITY_BITS-1:0] in_priority;
   logic [TAG_BITS-1:0]             in_finish_tag;
   logic [HANDLE_BITS-1:0]          out_handle;
   logic [TAG_BITS-1:0]             out_tag;
   logic [OCC_BITS-1:0]             out_occupancy;

   // split the request item into its fields
   assign in_handle     = req_tdata[HANDLE_BITS-1:0];
   assign in_priority   = req_tdata[HANDLE_BITS +: PRIORITY_BITS];
   assign in_finish_tag = req_tdata[HANDLE_BITS + PRIORITY_BITS +: TAG_BITS];

   // handshake: accept in idle, execute once the result register can take a value
   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .ctl        (ctl)
   );

   // sorted cell row, tag map and result register
   spq_datapath #(
      .DEPTH         (DEPTH),
      .PRIORITY_BITS (PRIORITY_BITS),
      .HANDLE_BITS   (HANDLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .req_cmd        (req_tuser),
      .req_handle     (in_handle),
      .req_priority   (in_priority),
      .req_finish_tag (in_finish_tag),
      .rsp_status     (rsp_tuser),
      .rsp_handle     (out_handle),
      .rsp_tag        (out_tag),
      .rsp_occupancy  (out_occupancy)
   );

   // pack the result item, zero pad in the top bits
   assign rsp_tdata = RSP_DATA_W'({out_occupancy, out_tag, out_handle});

endmodule

// File: rtl/spq_checker.sv
// Port checker of the stable priority task queue and its bind.
module spq_checker #(
   parameter int DEPTH         = spq_pkg::DEPTH_DEFAULT,
   parameter int HANDLE_BITS   = spq_pkg::HANDLE_BITS_DEFAULT,
   localparam int TAG_BITS     = $clog2(DEPTH),
   localparam int OCC_BITS     = $clog2(DEPTH + 1),
   localparam int RSP_BITS     = HANDLE_BITS + TAG_BITS + OCC_BITS,
   localparam int RSP_DATA_W   = ((RSP_BITS + 7) / 8) * 8
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [RSP_DATA_W-1:0]           rsp_tdata,
   input logic [spq_pkg::STATUS_BITS-1:0] rsp_tuser
);

   logic [OCC_BITS-1:0]    occ;
   logic [HANDLE_BITS-1:0] hndl;
   logic [TAG_BITS-1:0]    tag;

   assign hndl = rsp_tdata[HANDLE_BITS-1:0];
   assign tag  = rsp_tdata[HANDLE_BITS +: TAG_BITS];
   assign occ  = rsp_tdata[HANDLE_BITS + TAG_BITS +: OCC_BITS];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // occupancy never passes the depth
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> occ <= OCC_BITS'(DEPTH))
      else $error("occupancy beyond depth");

   // full only when every slot is taken
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == spq_pkg::STATUS_FULL) |-> occ == OCC_BITS'(DEPTH))
      else $error("full reported below depth");

   // a failed command returns no handle and no tag
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != spq_pkg::STATUS_OK) |-> hndl == '0 && tag == '0)
      else $error("failed command returned data");

   // no item is taken while its predecessor is still being worked on
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted back to back");

endmodule

bind stable_priority_task_queue spq_checker #(
   .DEPTH         (DEPTH),
   .HANDLE_BITS   (HANDLE_BITS)
) u_spq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: test/stable_priority_task_queue_checker.sv
// Checker of the stable priority task queue: predicts every result and compares it.
module stable_priority_task_queue_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [31:0]                     req_tdata,
   input  logic [spq_pkg::CMD_BITS-1:0]    req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [31:0]                     rsp_tdata,
   input  logic [spq_pkg::STATUS_BITS-1:0] rsp_tuser,
   output int                              error_count,
   output int                              pending,
   output logic [15:0]                     busy_tags,
   output int                              full_seen,
   output int                              no_head_seen,
   output int                              bad_tag_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = 16;

   typedef struct packed {
      logic [spq_pkg::STATUS_BITS-1:0] status;
      logic [15:0]                     handle;
      logic [3:0]                      tag;
      logic [4:0]                      occupancy;
   } queue_result_type;

   // predicted queue contents, slot 0 at the head, valid up to queue_len
   int                 queue_len;
   logic signed [7:0]  slot_priority [SLOTS];
   logic [15:0]        slot_handle [SLOTS];
   logic [3:0]         slot_tag [SLOTS];
   logic               slot_busy [SLOTS];
   logic [15:0]        tag_free;
   queue_result_type   expected_results [$];

   initial begin
      error_count  = 0;
      full_seen    = 0;
      no_head_seen = 0;
      bad_tag_seen = 0;
   end

   task automatic clear_queue;
      queue_len = 0;
      tag_free  = '1;
      for (int i = 0; i < SLOTS; i++) begin
         slot_priority[i] = '0;
         slot_handle[i]   = '0;
         slot_tag[i]      = '0;
         slot_busy[i]     = 1'b0;
      end
   endtask

   task automatic copy_slot(input int dst, input int src);
      slot_priority[dst] = slot_priority[src];
      slot_handle[dst]   = slot_handle[src];
      slot_tag[dst]      = slot_tag[src];
      slot_busy[dst]     = slot_busy[src];
   endtask

   // apply one command to the predicted queue and return the result it causes
   task automatic apply_command(input logic [spq_pkg::CMD_BITS-1:0] cmd,
                                input logic [15:0] handle,
                                input logic signed [7:0] prio, input logic [3:0] ftag,
                                output queue_result_type res);
      int pos;
      int new_tag;
      res = '0;
      case (cmd)
         spq_pkg::CMD_INSERT: begin
            if (queue_len >= SLOTS) begin
               res.status = spq_pkg::STATUS_FULL;
            end else begin
               new_tag = 0;
               while (new_tag < SLOTS && !tag_free[new_tag]) new_tag++;
               // ties go behind every entry of equal priority
               pos = 0;
               while (pos < queue_len && slot_priority[pos] <= prio) pos++;
               for (int k = queue_len; k > pos; k--) copy_slot(k, k - 1);
               slot_priority[pos] = prio;
               slot_handle[pos]   = handle;
               slot_tag[pos]      = new_tag[3:0];
               slot_busy[pos]     = 1'b0;
               tag_free[new_tag]  = 1'b0;
               queue_len++;
               res.tag = new_tag[3:0];
            end
         end
         spq_pkg::CMD_DISPATCH: begin
            if (queue_len == 0 || slot_busy[0]) begin
               res.status = spq_pkg::STATUS_NO_HEAD;
            end else begin
               slot_busy[0] = 1'b1;
               res.handle   = slot_handle[0];
               res.tag      = slot_tag[0];
            end
         end
         spq_pkg::CMD_FINISH: begin
            // the busy entry may have been pushed back by later inserts
            pos = 0;
            while (pos < queue_len && !(slot_tag[pos] == ftag && slot_busy[pos])) pos++;
            if (pos >= queue_len) begin
               res.status = spq_pkg::STATUS_BAD_TAG;
            end else begin
               for (int k = pos; k + 1 < queue_len; k++) copy_slot(k, k + 1);
               slot_busy[queue_len-1] = 1'b0;
               tag_free[ftag] = 1'b1;
               queue_len--;
               res.tag = ftag;
            end
         end
         default: ;
      endcase
      res.occupancy = queue_len[4:0];
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h",
                  $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin : monitor
      queue_result_type want;
      queue_result_type predicted;
      if (reset) begin
         clear_queue();
         expected_results.delete();
      end else begin
         // a result at this edge always belongs to an earlier item
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t ns: result with nothing expected, expected none, actual %0h/%0h",
                        $time, rsp_tuser, rsp_tdata);
            end else begin
               want = expected_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_tuser));
               check_field("out_handle", 32'(want.handle), 32'(rsp_tdata[15:0]));
               check_field("out_tag", 32'(want.tag), 32'(rsp_tdata[19:16]));
               check_field("occupancy", 32'(want.occupancy), 32'(rsp_tdata[24:20]));
               check_field("pad", 32'd0, 32'(rsp_tdata[31:25]));
               case (want.status)
                  spq_pkg::STATUS_FULL:    full_seen++;
                  spq_pkg::STATUS_NO_HEAD: no_head_seen++;
                  spq_pkg::STATUS_BAD_TAG: bad_tag_seen++;
                  default: ;
               endcase
            end
         end
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser, req_tdata[15:0], $signed(req_tdata[23:16]),
                          req_tdata[27:24], predicted);
            expected_results.push_back(predicted);
         end
      end
      pending = expected_results.size();
      for (int i = 0; i < SLOTS; i++)
         busy_tags[i] = 1'b0;
      for (int i = 0; i < queue_len; i++)
         if (slot_busy[i]) busy_tags[slot_tag[i]] = 1'b1;
   end

endmodule

// File: test/stable_priority_task_queue_tb.sv
// Testbench top of the stable priority task queue: stimulus, receiver pattern and verdict.
module stable_priority_task_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS     = 1000;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int HOLD_INSERTS     = 24;   // more than the queue holds, so full is hit
   localparam int DRAIN_CYCLES     = 8;
   localparam logic [spq_pkg::CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   // traffic mixes of the random phases
   typedef enum {
      MIX_BALANCED,
      MIX_FILL,
      MIX_DRAIN,
      MIX_NOISE
   } mix_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   // task_handle, task_priority, finish_tag (lowest bit up), zero pad
   logic [31:0]                     req_tdata;
   // cmd
   logic [spq_pkg::CMD_BITS-1:0]    req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   // out_handle, out_tag, occupancy (lowest bit up), zero pad
   logic [31:0]                     rsp_tdata;
   // status
   logic [spq_pkg::STATUS_BITS-1:0] rsp_tuser;

   int          error_count;
   int          pending;
   logic [15:0] busy_tags;
   int          full_seen;
   int          no_head_seen;
   int          bad_tag_seen;

   int          inserts_sent;
   int          dispatches_sent;
   int          finishes_sent;
   int          unused_sent;
   bit          hold_request;

   always #1 clock = ~clock;

   stable_priority_task_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   stable_priority_task_queue_checker scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .error_count  (error_count),
      .pending      (pending),
      .busy_tags    (busy_tags),
      .full_seen    (full_seen),
      .no_head_seen (no_head_seen),
      .bad_tag_seen (bad_tag_seen)
   );

   // Offer one item from the current falling edge and hold it until the
   // rising edge that accepts it. The caller has already moved to the falling edge.
   task automatic drive_item(input logic [spq_pkg::CMD_BITS-1:0] cmd,
                             input logic [15:0] handle,
                             input logic [7:0] prio, input logic [3:0] ftag);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {4'b0000, ftag, prio, handle};
      do @(posedge clock); while (req_tready !== 1'b1);
      case (cmd)
         spq_pkg::CMD_INSERT:   inserts_sent++;
         spq_pkg::CMD_DISPATCH: dispatches_sent++;
         spq_pkg::CMD_FINISH:   finishes_sent++;
         default:               unused_sent++;
      endcase
   endtask

   // Favor extremes and a narrow band so that ties happen often.
   function automatic logic [7:0] pick_priority();
      logic [7:0] prio;
      case ($urandom_range(0, 2))
         0: begin
            case ($urandom_range(0, 3))
               0: prio = 8'h80;
               1: prio = 8'hFF;
               2: prio = 8'h00;
               default: prio = 8'h7F;
            endcase
         end
         1: prio = 8'($urandom_range(0, 7));
         default: prio = 8'($urandom);
      endcase
      return prio;
   endfunction

   // Pick the next command for the given mix. Finishes mostly name a tag that
   // is really in service, otherwise they would almost never succeed.
   task automatic pick_item(input mix_type mix, output logic [spq_pkg::CMD_BITS-1:0] cmd,
                            output logic [15:0] handle, output logic [7:0] prio,
                            output logic [3:0] ftag);
      int roll;
      int insert_pct;
      int dispatch_pct;
      int k;
      roll   = $urandom_range(0, 99);
      handle = 16'($urandom);
      prio   = pick_priority();
      ftag   = 4'($urandom);
      case (mix)
         MIX_FILL: begin
            insert_pct   = 70;
            dispatch_pct = 20;
         end
         MIX_DRAIN: begin
            insert_pct   = 15;
            dispatch_pct = 40;
         end
         MIX_NOISE: begin
            insert_pct   = 30;
            dispatch_pct = 30;
         end
         default: begin
            insert_pct   = 40;
            dispatch_pct = 30;
         end
      endcase
      if (roll < insert_pct)
         cmd = spq_pkg::CMD_INSERT;
      else if (roll < insert_pct + dispatch_pct)
         cmd = spq_pkg::CMD_DISPATCH;
      else if (mix == MIX_NOISE && roll >= 88)
         cmd = CMD_UNUSED;
      else
         cmd = spq_pkg::CMD_FINISH;
      if (cmd == spq_pkg::CMD_FINISH && busy_tags != '0 &&
          (mix != MIX_NOISE || $urandom_range(0, 1) == 0)) begin
         k = $urandom_range(0, 15);
         while (!busy_tags[k]) k = (k + 1) % 16;
         ftag = k[3:0];
      end
   endtask

   // Drop valid and hold off until every expected result has come back.
   task automatic wait_until_drained;
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // Receiver: stretches of random readiness, plus one long hold on request.
   initial begin : receiver
      int stretch;
      int ready_pct;
      bit hold_taken;
      rsp_tready = 1'b0;
      stretch    = 0;
      ready_pct  = 100;
      hold_taken = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            if (stretch == 0) begin
               stretch = $urandom_range(1, 60);
               case ($urandom_range(0, 3))
                  0: ready_pct = 100;
                  1: ready_pct = 70;
                  2: ready_pct = 40;
                  default: ready_pct = 10;
               endcase
            end
            stretch--;
            rsp_tready <= ($urandom_range(0, 99) < ready_pct);
         end
      end
   end

   // Stimulus: directed opening, random phases, then drain and verdict.
   initial begin : stimulus
      logic [spq_pkg::CMD_BITS-1:0] cmd;
      logic [15:0]                  handle;
      logic [7:0]                   prio;
      logic [3:0]                   ftag;
      mix_type                      mix;
      int                           items_left;
      int                           phase_items;
      int                           burst;
      int                           gap;
      bit                           hold_done;
      bit                           pause_done;

      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = spq_pkg::CMD_INSERT;
      hold_request = 1'b0;
      inserts_sent    = 0;
      dispatches_sent = 0;
      finishes_sent   = 0;
      unused_sent     = 0;
      hold_done  = 1'b0;
      pause_done = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // empty queue: nothing to dispatch, no tag to finish, unused code is a no-op
      @(negedge clock); drive_item(spq_pkg::CMD_DISPATCH, 16'h0000, 8'h00, 4'h0);
      @(negedge clock); drive_item(spq_pkg::CMD_FINISH,   16'h0000, 8'h00, 4'hF);
      @(negedge clock); drive_item(CMD_UNUSED,            16'hFFFF, 8'hFF, 4'hF);
      // tag 0 at the top priority, tag 1 in front of it, then serve tag 1
      @(negedge clock); drive_item(spq_pkg::CMD_INSERT,   16'hFFFF, 8'h7F, 4'h0);
      @(negedge clock); drive_item(spq_pkg::CMD_INSERT,   16'h0000, 8'h05, 4'hF);
      @(negedge clock); drive_item(spq_pkg::CMD_DISPATCH, 16'h0000, 8'h00, 4'h0);
      // lowest priority jumps ahead of the busy head; equal top priority queues behind
      @(negedge clock); drive_item(spq_pkg::CMD_INSERT,   16'hA5A5, 8'h80, 4'h0);
      @(negedge clock); drive_item(spq_pkg::CMD_INSERT,   16'h5A5A, 8'h7F, 4'h0);
      // finish of a waiting entry is refused
      @(negedge clock); drive_item(spq_pkg::CMD_FINISH,   16'h0000, 8'h00, 4'h0);
      @(negedge clock); drive_item(spq_pkg::CMD_DISPATCH, 16'h0000, 8'h00, 4'h0);
      // busy head blocks dispatch
      @(negedge clock); drive_item(spq_pkg::CMD_DISPATCH, 16'h0000, 8'h00, 4'h0);
      // finish a busy entry that was pushed back, then the same tag again, then the busy head
      @(negedge clock); drive_item(spq_pkg::CMD_FINISH,   16'h0000, 8'h00, 4'h1);
      @(negedge clock); drive_item(spq_pkg::CMD_FINISH,   16'h0000, 8'h00, 4'h1);
      @(negedge clock); drive_item(spq_pkg::CMD_FINISH,   16'h0000, 8'h00, 4'h2);
      // ties served in arrival order
      @(negedge clock); drive_item(spq_pkg::CMD_DISPATCH, 16'h0000, 8'h00, 4'h0);
      @(negedge clock); drive_item(spq_pkg::CMD_FINISH,   16'h0000, 8'h00, 4'h0);
      @(negedge clock); drive_item(spq_pkg::CMD_DISPATCH, 16'h0000, 8'h00, 4'h0);
      @(negedge clock); drive_item(spq_pkg::CMD_FINISH,   16'h0000, 8'h00, 4'h3);
      wait_until_drained();

      items_left = RANDOM_ITEMS;
      while (items_left > 0) begin
         mix         = mix_type'($urandom_range(0, 3));
         phase_items = $urandom_range(40, 120);
         while (phase_items > 0 && items_left > 0) begin
            burst = $urandom_range(1, 16);
            gap   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            repeat (burst) begin
               // long receiver hold: send more inserts than the queue holds, so that it fills,
               // while the input stalls behind the unread result
               if (!hold_done && items_left <= RANDOM_ITEMS - 300) begin
                  hold_done    = 1'b1;
                  hold_request = 1'b1;
                  repeat (HOLD_INSERTS) begin
                     @(negedge clock);
                     drive_item(spq_pkg::CMD_INSERT, 16'($urandom), pick_priority(),
                                4'($urandom));
                  end
               end
               @(negedge clock);
               pick_item(mix, cmd, handle, prio, ftag);
               drive_item(cmd, handle, prio, ftag);
               items_left--;
               phase_items--;
            end
            repeat (gap) begin
               @(negedge clock);
               req_tvalid <= 1'b0;
            end
         end
         if ((!pause_done && items_left < RANDOM_ITEMS / 2) || $urandom_range(0, 3) == 0) begin
            pause_done = 1'b1;
            wait_until_drained();
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("summary: %0d insert, %0d dispatch, %0d finish, %0d unused-code items sent",
               inserts_sent, dispatches_sent, finishes_sent, unused_sent);
      $display("summary: results with queue full %0d, head empty or busy %0d, tag unknown %0d",
               full_seen, no_head_seen, bad_tag_seen);
      if (error_count == 0) begin
         $display("stable_priority_task_queue_tb: clean");
      end else begin
         $display("stable_priority_task_queue_tb: errors");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #400000;
      $display("stable_priority_task_queue_tb: errors");
      $finish;
   end

endmodule

// File: filelist.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/stable_priority_task_queue.sv
rtl/spq_checker.sv
test/stable_priority_task_queue_checker.sv
test/stable_priority_task_queue_tb.sv
